### rtl/assert_macros.svh
// Assertion macros shared by the touch wheel RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/twv_pkg.sv
// Package for the touch wheel value tracker: types, register indexes and the pad table.
// No dependencies.
`default_nettype none

package twv_pkg;

   localparam int DefaultValueWidth = 16;
   localparam int LimitWidth        = 16;
   localparam int StepWidth         = 15;
   localparam int PadWidth          = 4;

   typedef enum logic [1:0] {
      ModeSwitch       = 2'd0,
      ModeRotarySwitch = 2'd1,
      ModeAbsolute     = 2'd2,
      ModeRelative     = 2'd3
   } mode_type;

   localparam logic [1:0] CsrMode       = 2'd0;
   localparam logic [1:0] CsrUpperLimit = 2'd1;
   localparam logic [1:0] CsrLowerLimit = 2'd2;
   localparam logic [1:0] CsrStepSize   = 2'd3;

   localparam logic signed [LimitWidth-1:0] ResetUpperLimit = 16'sd32;
   localparam logic signed [LimitWidth-1:0] ResetLowerLimit = 16'sd0;
   localparam logic [StepWidth-1:0]         ResetStepSize   = 15'd2;

   localparam logic signed [3:0] PosNoTouch = -4'sd1;
   localparam logic signed [3:0] PosHold    = -4'sd2;

   typedef struct packed {
      mode_type                       mode;
      logic signed [LimitWidth-1:0]   upper_limit;
      logic signed [LimitWidth-1:0]   lower_limit;
      logic [StepWidth-1:0]           step_size;
   } cfg_type;

   // Ring pad pattern to wheel position, or no touch / hold.
   function automatic logic signed [3:0] pos_of(input logic [2:0] ring);
      logic signed [3:0] pos;
      case (ring)
         3'd0: pos = PosNoTouch;
         3'd1: pos = 4'sd0;
         3'd2: pos = 4'sd2;
         3'd3: pos = 4'sd1;
         3'd4: pos = 4'sd4;
         3'd5: pos = 4'sd5;
         3'd6: pos = 4'sd3;
         default: pos = PosHold;
      endcase
      return pos;
   endfunction

endpackage

`default_nettype wire

### rtl/twv_core.sv
// Next-value logic of the touch wheel tracker: decodes one sample against the history.
// Depends on twv_pkg.
`default_nettype none

module twv_core #(
   parameter int VALUE_WIDTH = twv_pkg::DefaultValueWidth
) (
   input  twv_pkg::cfg_type                 cfg,
   input  logic [twv_pkg::PadWidth-1:0]     pad_bits,
   input  logic [twv_pkg::PadWidth-1:0]     last_pad_bits,
   input  logic [twv_pkg::PadWidth-1:0]     older_pad_bits,
   input  logic signed [VALUE_WIDTH-1:0]    held_value,
   output logic signed [VALUE_WIDTH-1:0]    next_value,
   output logic                             changed
);
   import twv_pkg::*;

   localparam int CalcWidth =
      ((VALUE_WIDTH > LimitWidth) ? VALUE_WIDTH : LimitWidth) + 2;
   localparam logic signed [CalcWidth-1:0] MaxValue =
      {{(CalcWidth-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [CalcWidth-1:0] MinValue = ~MaxValue;

   function automatic logic signed [CalcWidth-1:0] sat(input logic signed [CalcWidth-1:0] v);
      logic signed [CalcWidth-1:0] r;
      if (v > MaxValue) begin
         r = MaxValue;
      end else if (v < MinValue) begin
         r = MinValue;
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic signed [3:0]           pos;
   logic signed [3:0]           pos_a;
   logic signed [3:0]           pos_b;
   logic [2:0]                  fwd_a;
   logic [2:0]                  back_a;
   logic                        move_up;
   logic                        move_down;
   logic signed [CalcWidth-1:0] held_ext;
   logic signed [CalcWidth-1:0] upper_ext;
   logic signed [CalcWidth-1:0] lower_ext;
   logic signed [CalcWidth-1:0] inc_ext;
   logic signed [CalcWidth-1:0] sum;
   logic signed [CalcWidth-1:0] diff;
   logic signed [CalcWidth-1:0] next_ext;

   always_comb begin
      pos   = pos_of(pad_bits[2:0]);
      pos_a = pos_of(older_pad_bits[2:0]);
      pos_b = pos_of(last_pad_bits[2:0]);
      fwd_a  = (pos_a[2:0] == 3'd5) ? 3'd0 : pos_a[2:0] + 3'd1;
      back_a = (pos_a[2:0] == 3'd0) ? 3'd5 : pos_a[2:0] - 3'd1;
      move_up   = !pos_a[3] && !pos_b[3] && (pos_a != pos_b) && (pos_b[2:0] == fwd_a);
      move_down = !pos_a[3] && !pos_b[3] && (pos_a != pos_b) && (pos_b[2:0] == back_a);

      held_ext  = {{(CalcWidth-VALUE_WIDTH){held_value[VALUE_WIDTH-1]}}, held_value};
      upper_ext = {{(CalcWidth-LimitWidth){cfg.upper_limit[LimitWidth-1]}}, cfg.upper_limit};
      lower_ext = {{(CalcWidth-LimitWidth){cfg.lower_limit[LimitWidth-1]}}, cfg.lower_limit};
      inc_ext   = last_pad_bits[3] ? CalcWidth'(1)
                                   : {{(CalcWidth-StepWidth){1'b0}}, cfg.step_size};
      sum  = held_ext + inc_ext;
      diff = held_ext - inc_ext;

      next_ext = held_ext;
      changed  = 1'b0;
      case (cfg.mode)
         ModeSwitch: begin
            if (pos == PosNoTouch) begin
               next_ext = -CalcWidth'(1);
            end else if (pos != PosHold) begin
               next_ext = {{(CalcWidth-2){1'b0}}, pos[2:1]};
            end
            changed = (next_ext != held_ext);
         end
         ModeRotarySwitch: begin
            if (pos != PosHold) begin
               next_ext = {{(CalcWidth-4){pos[3]}}, pos};
               changed  = 1'b1;
            end
         end
         ModeAbsolute: begin
            if (pad_bits[2:0] != 3'd0) begin
               if (move_up && (held_ext < upper_ext)) begin
                  next_ext = sat((sum < upper_ext) ? sum : upper_ext);
               end else if (move_down && (held_ext > lower_ext)) begin
                  next_ext = sat((diff > lower_ext) ? diff : lower_ext);
               end
            end
            changed = (next_ext != held_ext);
         end
         ModeRelative: begin
            if ((pad_bits[2:0] != 3'd0) && (move_up || move_down)) begin
               next_ext = sat(move_up ? inc_ext : -inc_ext);
               changed  = 1'b1;
            end
         end
         default: begin
            next_ext = held_ext;
            changed  = 1'b0;
         end
      endcase
      next_value = next_ext[VALUE_WIDTH-1:0];
   end

endmodule

`default_nettype wire

### rtl/touch_wheel_value_tracker.sv
// Path: an accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle while rsp_stall is low; the value state updates as an item leaves the input register.
// A waiting result stalls the input only once the input register also holds an item.
// Reset (synchronous, active high): history cleared, value set to -1, registers to their defaults.
// Top level of the touch wheel value tracker; depends on twv_pkg, twv_core and assert_macros.svh.
`default_nettype none

module touch_wheel_value_tracker #(
   parameter int VALUE_WIDTH = twv_pkg::DefaultValueWidth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [twv_pkg::PadWidth-1:0]      req_pad_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]     rsp_value_out,
   output logic                              rsp_changed,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [twv_pkg::LimitWidth-1:0]    csr_wdata
);
   import twv_pkg::*;
   `include "assert_macros.svh"

   cfg_type                       cfg_ff;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [PadWidth-1:0]           s1_pad_ff;
   logic [PadWidth-1:0]           last_pad_ff;
   logic [PadWidth-1:0]           older_pad_ff;
   logic signed [VALUE_WIDTH-1:0] held_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                          rsp_changed_ff;
   logic signed [VALUE_WIDTH-1:0] next_value;
   logic                          next_changed;
   logic                          s1_advance;
   logic                          s1_fire;
   logic                          req_accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= ModeSwitch;
         cfg_ff.upper_limit <= ResetUpperLimit;
         cfg_ff.lower_limit <= ResetLowerLimit;
         cfg_ff.step_size   <= ResetStepSize;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrMode:       cfg_ff.mode        <= mode_type'(csr_wdata[1:0]);
            CsrUpperLimit: cfg_ff.upper_limit <= csr_wdata;
            CsrLowerLimit: cfg_ff.lower_limit <= csr_wdata;
            CsrStepSize:   cfg_ff.step_size   <= csr_wdata[StepWidth-1:0];
            default:       cfg_ff.mode        <= cfg_ff.mode;
         endcase
      end
   end

   always_comb begin
      s1_advance   = !rsp_valid_ff || !rsp_stall;
      s1_fire      = s1_valid_ff && s1_advance;
      req_stall    = s1_valid_ff && !s1_advance;
      req_accept   = req_valid && !req_stall;
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
      rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);
   end

   twv_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_core (
      .cfg            (cfg_ff),
      .pad_bits       (s1_pad_ff),
      .last_pad_bits  (last_pad_ff),
      .older_pad_bits (older_pad_ff),
      .held_value     (held_ff),
      .next_value     (next_value),
      .changed        (next_changed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_pad_ff  <= '0;
         older_pad_ff <= '0;
         held_ff      <= -VALUE_WIDTH'(1);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            older_pad_ff <= last_pad_ff;
            last_pad_ff  <= s1_pad_ff;
            held_ff      <= next_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pad_ff <= req_pad_bits;
      end
      if (s1_fire) begin
         rsp_value_ff   <= next_value;
         rsp_changed_ff <= next_changed;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_changed   = rsp_changed_ff;

   `ASSERT_IMPLIES(a_stall_needs_item, req_stall, s1_valid_ff, "input stalled with no item held")
   `ASSERT_NEXT(a_fire_gives_result, s1_fire, rsp_valid_ff, "item left the input register but no result")
   `ASSERT_NEXT(a_history_shift, s1_fire, last_pad_ff == $past(s1_pad_ff), "sample history not updated")
   `ASSERT_NEXT(a_result_tracks_value, s1_fire, rsp_value_ff == held_ff, "result differs from the value state")
   `ASSERT_NEXT(a_abs_changed, s1_fire && (cfg_ff.mode == ModeAbsolute), rsp_changed_ff == (held_ff != $past(held_ff)), "absolute mode change flag wrong")

endmodule

`default_nettype wire

### dv/wheel_value_compare.sv
`timescale 1ns / 1ps
// Result checker for the touch wheel value tracker: follows register writes and accepted
// pad samples, predicts each value and changed flag, and compares them with the results.
// Depends on twv_pkg for the mode enum, register indexes and reset defaults.

module wheel_value_compare #(
   parameter int VALUE_WIDTH = twv_pkg::DefaultValueWidth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [twv_pkg::PadWidth-1:0]   req_pad_bits,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic signed [VALUE_WIDTH-1:0]  rsp_value_out,
   input  logic                           rsp_changed,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [twv_pkg::LimitWidth-1:0] csr_wdata,
   output int                             pending,
   output int                             fail_count
);
   import twv_pkg::*;

   localparam int NoTouchPos     = PosNoTouch;
   localparam int HoldPos        = PosHold;
   localparam int WheelPositions = 6;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          changed;
   } wheel_result_type;

   mode_type         cur_mode;
   longint           upper_bound;
   longint           lower_bound;
   longint           step_amount;
   logic [3:0]       last_pads;
   logic [3:0]       older_pads;
   longint           held;
   int               fault_total = 0;
   wheel_result_type expected_q[$];

   function automatic int ring_position(input logic [2:0] ring);
      case (ring)
         3'b000: return NoTouchPos;
         3'b001: return 0;
         3'b011: return 1;
         3'b010: return 2;
         3'b110: return 3;
         3'b100: return 4;
         3'b101: return 5;
         default: return HoldPos;
      endcase
   endfunction

   function automatic longint clamp_to_width(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // The move is judged from the two samples before the current one.
   function automatic int wheel_direction();
      int from_pos;
      int to_pos;
      from_pos = ring_position(older_pads[2:0]);
      to_pos = ring_position(last_pads[2:0]);
      if (from_pos < 0 || to_pos < 0 || from_pos == to_pos) return 0;
      if (to_pos == (from_pos + 1) % WheelPositions) return 1;
      if (to_pos == (from_pos + WheelPositions - 1) % WheelPositions) return -1;
      return 0;
   endfunction

   function automatic wheel_result_type predict_wheel(input logic [3:0] pads);
      int               pos;
      int               dir;
      longint           prior;
      longint           inc;
      longint           t;
      wheel_result_type res;
      pos = ring_position(pads[2:0]);
      prior = held;
      res.changed = 1'b0;
      case (cur_mode)
         ModeSwitch: begin
            if (pos == NoTouchPos) held = NoTouchPos;
            else if (pos != HoldPos) held = pos / 2;
            res.changed = (held != prior);
         end
         ModeRotarySwitch: begin
            if (pos != HoldPos) begin
               held = pos;
               res.changed = 1'b1;
            end
         end
         default: begin
            if (pads[2:0] != 3'b000) begin
               dir = wheel_direction();
               inc = last_pads[3] ? 1 : step_amount;
               if (cur_mode == ModeAbsolute) begin
                  if (dir > 0 && held < upper_bound) begin
                     t = held + inc;
                     held = clamp_to_width(t < upper_bound ? t : upper_bound);
                  end else if (dir < 0 && held > lower_bound) begin
                     t = held - inc;
                     held = clamp_to_width(t > lower_bound ? t : lower_bound);
                  end
                  res.changed = (held != prior);
               end else if (dir != 0) begin
                  held = clamp_to_width(dir > 0 ? inc : -inc);
                  res.changed = 1'b1;
               end
            end
         end
      endcase
      older_pads = last_pads;
      last_pads = pads;
      res.value = held[VALUE_WIDTH-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      wheel_result_type want;
      if (reset) begin
         cur_mode = ModeSwitch;
         upper_bound = ResetUpperLimit;
         lower_bound = ResetLowerLimit;
         step_amount = ResetStepSize;
         last_pads = '0;
         older_pads = '0;
         held = NoTouchPos;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrMode:       cur_mode = mode_type'(csr_wdata[1:0]);
               CsrUpperLimit: upper_bound = $signed(csr_wdata);
               CsrLowerLimit: lower_bound = $signed(csr_wdata);
               CsrStepSize:   step_amount = csr_wdata[StepWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected item, value_out %0d changed %0b", $time,
                  rsp_value_out, rsp_changed);
               fault_total++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_value_out !== want.value) begin
                  $display("%0t: value_out expected %0d actual %0d", $time,
                     $signed(want.value), rsp_value_out);
                  fault_total++;
               end
               if (rsp_changed !== want.changed) begin
                  $display("%0t: changed expected %0b actual %0b", $time,
                     want.changed, rsp_changed);
                  fault_total++;
               end
            end
         end
         if (req_valid && !req_stall) expected_q.push_back(predict_wheel(req_pad_bits));
      end
      pending <= expected_q.size();
      fail_count <= fault_total;
   end

endmodule

### dv/touch_wheel_value_tracker_test.sv
`timescale 1ns / 1ps
// Top of the touch wheel value tracker testbench: clock, reset, pad samples and register writes.
// Depends on twv_pkg, the touch_wheel_value_tracker RTL and the wheel_value_compare checker.

module touch_wheel_value_tracker_test;
   import twv_pkg::*;

   localparam int LatencyCycles    = 4;
   localparam int SettingsPerPhase = 8;
   localparam int ItemsPerSetting  = 52;
   localparam int WalkLength       = 10;
   localparam logic [4*WalkLength-1:0] AbsoluteWalk =
      {4'h4, 4'h1, 4'h5, 4'h7, 4'h0, 4'h6, 4'h4, 4'hE, 4'h3, 4'h1};

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [PadWidth-1:0]           req_pad_bits = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [DefaultValueWidth-1:0] rsp_value_out;
   logic                          rsp_changed;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [1:0]                    csr_index = CsrMode;
   logic [LimitWidth-1:0]         csr_wdata = '0;
   int                            pending;
   int                            fail_count;

   int send_idle_pct  = 34;
   int recv_stall_pct = 56;
   int wheel_pos      = 0;
   int walk_dir       = 1;

   touch_wheel_value_tracker i_dut (.*);
   wheel_value_compare i_compare (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [2:0] ring_of_position(input int pos);
      case (pos)
         0: return 3'b001;
         1: return 3'b011;
         2: return 3'b010;
         3: return 3'b110;
         4: return 3'b100;
         default: return 3'b101;
      endcase
   endfunction

   // Mostly a finger sliding around the wheel, sometimes turning back, plus random noise.
   function automatic logic [3:0] next_random_pad();
      logic center;
      center = ($urandom_range(3) == 0);
      if ($urandom_range(99) < 20) return 4'($urandom_range(15));
      if ($urandom_range(99) < 15) walk_dir = -walk_dir;
      wheel_pos = (wheel_pos + walk_dir + 6) % 6;
      return {center, ring_of_position(wheel_pos)};
   endfunction

   task automatic send_pad(input logic [3:0] pads);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pad_bits <= pads;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LatencyCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input mode_type mode);
      logic [15:0] upper;
      logic [15:0] lower;
      logic [15:0] step;
      case ($urandom_range(4))
         0: begin
            upper = 16'h7FFF;
            lower = 16'h8000;
         end
         1: begin
            upper = 16'h8000;
            lower = 16'h7FFF;
         end
         2: begin
            upper = 16'($urandom);
            lower = 16'($urandom);
         end
         default: begin
            lower = 16'($urandom_range(80) - 40);
            upper = lower + 16'($urandom_range(60));
         end
      endcase
      case ($urandom_range(4))
         0: step = 16'h0000;
         1: step = 16'h7FFF;
         2: step = 16'($urandom);
         default: step = 16'($urandom_range(8, 1));
      endcase
      step[15] = $urandom_range(1);
      write_reg(CsrMode, {14'($urandom), mode});
      write_reg(CsrUpperLimit, upper);
      write_reg(CsrLowerLimit, lower);
      write_reg(CsrStepSize, step);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 16; p++) send_pad(4'(p));
      drain();
      write_reg(CsrMode, {14'h0, ModeAbsolute});
      for (int i = 0; i < WalkLength; i++) send_pad(AbsoluteWalk[4*i +: 4]);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 56 : 0;
         recv_stall_pct = (phase == 0) ? 56 : (phase == 1) ? 34 : 0;
         for (int s = 0; s < SettingsPerPhase; s++) begin
            drain();
            apply_setting(mode_type'(s % 4));
            repeat (ItemsPerSetting) send_pad(next_random_pad());
         end
      end
      drain();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
